[design/spl_pkg.sv]
// sorted priority list: shared types, field widths and codes
// no dependencies; imported by sorted_priority_list_top and its testbench
`default_nettype none

package spl_pkg;

    // field widths
    localparam int KEY_W = 32;
    localparam int PRI_W = 8;
    localparam int ENTRY_W = KEY_W + PRI_W;

    // default table depth
    localparam int CAPACITY_DEFAULT = 16;

    // command codes
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_PRINT  = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ROW       = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

`default_nettype wire

[design/spl_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on nothing; used by the sorted priority list for its entry table
`default_nettype none

module spl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/sorted_priority_list_top.sv]
// sorted priority list: (key, priority) table kept in descending priority order
// depends on spl_pkg and spl_ram
//
//   channel   handshake            payload
//   command   start / busy         action, entry_key, priority_req
//   result    strobe (no stall)    status, out_key, out_priority, last
//
// a command beat is taken when start is high and busy is low
// clear, add to a full table, remove from an empty table and print of an
// empty table: one result the cycle after the command
// add: entries are read from the tail toward the head, and each entry of lower
// priority is moved one slot toward the tail until it stops behind a kept entry
// or reaches the head; then the new entry is written. remove: every table entry
// is read and later entries close the gap; print: one row per entry, head first
// each step goes through the single ram read port and its registered read
// reset empties the table at once; results cannot be held off
`default_nettype none

module sorted_priority_list_top
    import spl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       action,
    input  wire logic [KEY_W-1:0] entry_key,
    input  wire logic [PRI_W-1:0] priority_req,
    output logic                  strobe,
    output logic [2:0]            status,
    output logic [KEY_W-1:0]      out_key,
    output logic [PRI_W-1:0]      out_priority,
    output logic                  last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PUT
    } state_t;

    state_t            state_reg;
    action_t           op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic              found_reg;
    logic              strobe_reg;
    status_t           status_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [PRI_W-1:0]  out_pri_reg;
    logic              last_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [PRI_W-1:0]  rd_pri;
    logic              pri_ge;
    logic              key_hit;
    logic              at_end;
    logic [CNT_W-1:0]  ptr_dec;
    logic [CNT_W-1:0]  ptr_inc;
    action_t           cmd_action;

    assign cmd_action = action_t'(action);
    assign rd_key     = ram_rdata[ENTRY_W-1:PRI_W];
    assign rd_pri     = ram_rdata[PRI_W-1:0];

    // shared compare unit and pointer steps
    assign pri_ge  = rd_pri >= pri_reg;
    assign key_hit = rd_key == key_reg;
    assign ptr_dec = ptr_reg - ONE_CNT;
    assign ptr_inc = ptr_reg + ONE_CNT;
    assign at_end  = ptr_inc == count_reg;

    // entry table port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg[IDX_W-1:0];
        case (state_reg)
            S_READ:
            begin
                if (op_reg == ACT_ADD)
                begin
                    ram_raddr = ptr_dec[IDX_W-1:0];
                end
            end
            S_EVAL:
            begin
                if (op_reg == ACT_ADD)
                begin
                    // move a lower-priority entry one slot toward the tail
                    ram_we = !pri_ge;
                end
                else if (op_reg == ACT_REMOVE)
                begin
                    // close the gap left by the removed entry
                    ram_we    = found_reg;
                    ram_waddr = ptr_dec[IDX_W-1:0];
                end
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {key_reg, pri_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    spl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // command sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= ACT_ADD;
            key_reg     <= '0;
            pri_reg     <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            found_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
            status_reg  <= ST_DONE;
            out_key_reg <= '0;
            out_pri_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg      <= cmd_action;
                        key_reg     <= entry_key;
                        pri_reg     <= priority_req;
                        found_reg   <= 1'b0;
                        out_key_reg <= '0;
                        out_pri_reg <= '0;
                        last_reg    <= 1'b1;
                        case (cmd_action)
                            ACT_ADD:
                            begin
                                if (count_reg == CAP_CNT)
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    ptr_reg   <= count_reg;
                                    state_reg <= (count_reg == '0) ? S_PUT : S_READ;
                                end
                            end
                            ACT_REMOVE:
                            begin
                                if (count_reg == '0)
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= ST_NOT_FOUND;
                                end
                                else
                                begin
                                    ptr_reg   <= '0;
                                    state_reg <= S_READ;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                count_reg  <= '0;
                                strobe_reg <= 1'b1;
                                status_reg <= ST_DONE;
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    ptr_reg   <= '0;
                                    state_reg <= S_READ;
                                end
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    case (op_reg)
                        ACT_ADD:
                        begin
                            // insertion point found, or entry moved down
                            if (pri_ge)
                            begin
                                state_reg <= S_PUT;
                            end
                            else
                            begin
                                ptr_reg   <= ptr_dec;
                                state_reg <= (ptr_reg == ONE_CNT) ? S_PUT : S_READ;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!found_reg && key_hit)
                            begin
                                found_reg <= 1'b1;
                            end
                            if (at_end)
                            begin
                                strobe_reg <= 1'b1;
                                last_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                                if (found_reg || key_hit)
                                begin
                                    count_reg  <= count_reg - ONE_CNT;
                                    status_reg <= ST_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                ptr_reg   <= ptr_inc;
                                state_reg <= S_READ;
                            end
                        end
                        default:
                        begin
                            // print one row beat
                            strobe_reg  <= 1'b1;
                            status_reg  <= ST_ROW;
                            out_key_reg <= rd_key;
                            out_pri_reg <= rd_pri;
                            last_reg    <= at_end;
                            ptr_reg     <= ptr_inc;
                            state_reg   <= at_end ? S_IDLE : S_READ;
                        end
                    endcase
                end
                S_PUT:
                begin
                    count_reg  <= count_reg + ONE_CNT;
                    strobe_reg <= 1'b1;
                    status_reg <= ST_DONE;
                    last_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign out_key      = out_key_reg;
    assign out_priority = out_pri_reg;
    assign last         = last_reg;

    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // the final beat of a command leaves the block ready
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final beat while still busy");

    // a row beat that is not final keeps the sequencer running
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy && status_reg == ST_ROW)
        else $error("non-final beat outside a print");

    // full status only when the table is at capacity
    a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status_reg == ST_FULL |-> count_reg == CAP_CNT)
        else $error("full reported below capacity");

    // the table is written only while a command is in progress
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("table write while idle");

endmodule

`default_nettype wire

[sim/tb_sorted_priority_list_top.sv]
// testbench for sorted_priority_list_top: directed command script, then random bursts
// depends on spl_pkg and the sorted_priority_list_top design; self-contained otherwise
module tb_sorted_priority_list_top;
    import spl_pkg::*;

    localparam int CAP = CAPACITY_DEFAULT;
    localparam int RANDOM_CMDS = 120;
    localparam int SCRIPT_ROWS = 22;
    localparam int MAX_PRINTED = 40;

    // one expected result beat
    typedef struct packed {
        status_t              st;
        logic [KEY_W-1:0]     key;
        logic [PRI_W-1:0]     pri;
        logic                 fin;
    } result_beat_t;

    // one row of the directed script; has_status marks a typed-in expectation
    typedef struct packed {
        action_t              act;
        logic [KEY_W-1:0]     key;
        logic [PRI_W-1:0]     pri;
        logic [4:0]           reps;
        logic                 has_status;
        status_t              st;
    } cmd_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       action = ACT_ADD;
    logic [KEY_W-1:0] entry_key = '0;
    logic [PRI_W-1:0] priority_req = '0;
    logic             busy;
    logic             strobe;
    logic [2:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [PRI_W-1:0] out_priority;
    logic             last;

    // side info travelling with the command beat
    logic             beat_has_status = 1'b0;
    status_t          beat_status = ST_DONE;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key [CAP];
    logic [PRI_W-1:0] shadow_pri [CAP];
    int               shadow_count = 0;

    result_beat_t     pending_results [$];
    result_beat_t     oldest;

    int mismatches = 0;
    int n_cmds = 0;
    int n_results = 0;
    int n_rows = 0;
    int n_full = 0;
    int n_missing = 0;
    int burst_left = 0;

    cmd_row_t script [SCRIPT_ROWS] = '{
        '{ACT_PRINT,  32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_EMPTY},
        '{ACT_REMOVE, 32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_NOT_FOUND},
        '{ACT_CLEAR,  32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_DONE},
        '{ACT_ADD,    32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_DONE},
        '{ACT_ADD,    32'hFFFF_FFFF, 8'hFF, 5'd1,  1'b1, ST_DONE},
        '{ACT_ADD,    32'h1234_5678, 8'h80, 5'd1,  1'b1, ST_DONE},
        '{ACT_ADD,    32'hA5A5_A5A5, 8'h80, 5'd1,  1'b1, ST_DONE},
        '{ACT_ADD,    32'h1234_5678, 8'h10, 5'd1,  1'b1, ST_DONE},
        '{ACT_PRINT,  32'h0000_0001, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_REMOVE, 32'h1234_5678, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_PRINT,  32'h0000_0000, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_REMOVE, 32'hDEAD_BEEF, 8'h00, 5'd1,  1'b1, ST_NOT_FOUND},
        '{ACT_ADD,    32'h5A5A_0000, 8'h40, 5'd12, 1'b0, ST_DONE},
        '{ACT_ADD,    32'hC0FF_EE00, 8'hFF, 5'd1,  1'b1, ST_FULL},
        '{ACT_PRINT,  32'h0000_0000, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_REMOVE, 32'h0000_0000, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_REMOVE, 32'hFFFF_FFFF, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_ADD,    32'h5A5A_0003, 8'h40, 5'd1,  1'b0, ST_DONE},
        '{ACT_REMOVE, 32'h5A5A_0003, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_PRINT,  32'h0000_0000, 8'h00, 5'd1,  1'b0, ST_DONE},
        '{ACT_CLEAR,  32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_DONE},
        '{ACT_PRINT,  32'h0000_0000, 8'h00, 5'd1,  1'b1, ST_EMPTY}
    };

    sorted_priority_list_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_key    (entry_key),
        .priority_req (priority_req),
        .strobe       (strobe),
        .status       (status),
        .out_key      (out_key),
        .out_priority (out_priority),
        .last         (last)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("timeout: %0d result beats still expected", pending_results.size());
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void push_result(input status_t st, input logic [KEY_W-1:0] key,
                                        input logic [PRI_W-1:0] pri, input logic fin);
        result_beat_t r;
        r.st = st;
        r.key = key;
        r.pri = pri;
        r.fin = fin;
        pending_results.push_back(r);
    endfunction

    // table update and expected result beats for one accepted command
    function automatic void table_command(input action_t act, input logic [KEY_W-1:0] key,
                                          input logic [PRI_W-1:0] pri);
        int pos;
        int i;
        pos = 0;
        case (act)
            ACT_ADD:
            begin
                if (shadow_count >= CAP)
                    push_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    // new entry goes after every entry of equal or higher priority
                    while (pos < shadow_count && shadow_pri[pos] >= pri)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_key[i] = shadow_key[i-1];
                        shadow_pri[i] = shadow_pri[i-1];
                    end
                    shadow_key[pos] = key;
                    shadow_pri[pos] = pri;
                    shadow_count++;
                    push_result(ST_DONE, '0, '0, 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                // first match in table order
                while (pos < shadow_count && shadow_key[pos] != key)
                    pos++;
                if (pos >= shadow_count)
                    push_result(ST_NOT_FOUND, '0, '0, 1'b1);
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i] = shadow_key[i+1];
                        shadow_pri[i] = shadow_pri[i+1];
                    end
                    shadow_count--;
                    push_result(ST_DONE, '0, '0, 1'b1);
                end
            end
            ACT_CLEAR:
            begin
                shadow_count = 0;
                push_result(ST_DONE, '0, '0, 1'b1);
            end
            default:
            begin
                if (shadow_count == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                for (i = 0; i < shadow_count; i++)
                    push_result(ST_ROW, shadow_key[i], shadow_pri[i], i + 1 == shadow_count);
            end
        endcase
    endfunction

    // result check, then prediction for a command beat taken at this edge
    always @(posedge clk)
    begin : result_check
        int first;
        if (rst_n)
        begin
            if (strobe)
            begin
                n_results++;
                if (status == ST_ROW)
                    n_rows++;
                if (status == ST_FULL)
                    n_full++;
                if (status == ST_NOT_FOUND)
                    n_missing++;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, status %0d key %h",
                                              status, out_key));
                else
                begin
                    oldest = pending_results.pop_front();
                    if (status !== oldest.st)
                        report_mismatch($sformatf("status %0d, want %s",
                                                  status, oldest.st.name()));
                    if (out_key !== oldest.key)
                        report_mismatch($sformatf("out_key %h, want %h", out_key, oldest.key));
                    if (out_priority !== oldest.pri)
                        report_mismatch($sformatf("out_priority %h, want %h",
                                                  out_priority, oldest.pri));
                    if (last !== oldest.fin)
                        report_mismatch($sformatf("last %b, want %b", last, oldest.fin));
                end
            end
            if (start && !busy)
            begin
                n_cmds++;
                first = pending_results.size();
                table_command(action_t'(action), entry_key, priority_req);
                // a typed-in status takes the place of the predicted one
                if (beat_has_status)
                    pending_results[first].st = beat_status;
            end
        end
    end

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // drive one command beat from a falling edge and hold it until taken
    task automatic send_cmd(input action_t act, input logic [KEY_W-1:0] key,
                            input logic [PRI_W-1:0] pri, input logic has_st,
                            input status_t st);
        action <= act;
        entry_key <= key;
        priority_req <= pri;
        beat_has_status <= has_st;
        beat_status <= st;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        pace();
    endtask

    // random command mix, mostly adds and removes, removes mostly of keys already present
    task automatic random_cmds();
        logic [KEY_W-1:0] key_pool [6];
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] pri;
        action_t          act;
        int               pick;
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(0, 99);
            key = ($urandom_range(0, 3) == 0) ? key_pool[$urandom_range(0, 5)] : $urandom();
            pri = PRI_W'($urandom());
            if (pick < 50)
            begin
                act = ACT_ADD;
                // half the priorities from a small set to force ties
                if ($urandom_range(0, 1) == 0)
                    pri = PRI_W'($urandom_range(0, 3) * 85);
            end
            else if (pick < 80)
            begin
                act = ACT_REMOVE;
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    key = shadow_key[$urandom_range(0, shadow_count - 1)];
            end
            else if (pick < 96)
                act = ACT_PRINT;
            else
                act = ACT_CLEAR;
            send_cmd(act, key, pri, 1'b0, ST_DONE);
        end
    endtask

    // main sequence
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed script
        for (int r = 0; r < SCRIPT_ROWS; r++)
            for (int k = 0; k < script[r].reps; k++)
                send_cmd(script[r].act, script[r].key + k, script[r].pri,
                         script[r].has_status, script[r].st);

        random_cmds();
        start <= 1'b0;

        // drain, then let the block settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAP + 8) @(posedge clk);

        $display("run covered %0d commands and %0d result beats:", n_cmds, n_results);
        $display("%0d entry rows, %0d full, %0d not found", n_rows, n_full, n_missing);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sorted_priority_list_top.f]
design/spl_pkg.sv
design/spl_ram.sv
design/sorted_priority_list_top.sv
sim/tb_sorted_priority_list_top.sv
